// ===== rtl/sfc32_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc32_pkg
// Shared types and constants for the start-word frame sync with CRC-32 check.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc32_pkg;

   localparam int FRAME_BYTES_DEF = 16;
   localparam int CRC_BYTES       = 4;

   localparam int BYTE_W       = 8;
   localparam int TIME_W       = 32;
   localparam int BYTE_INDEX_W = 6;
   localparam int START_WORD_W = 16;
   localparam int CRC_W        = 32;

   localparam logic [START_WORD_W-1:0] START_WORD_RESET = 16'hABCD;
   localparam logic [CRC_W-1:0]        CRC_POLY         = 32'hEDB88320;
   localparam logic [CRC_W-1:0]        CRC_INIT         = 32'hFFFFFFFF;
   localparam logic [CRC_W-1:0]        CRC_XOROUT       = 32'hFFFFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_RD0,
      ST_CHK_RD1,
      ST_CHK_CMP,
      ST_CRC_RD,
      ST_CRC_ACC,
      ST_CRC_CMP,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic              init;
      logic              step;
      logic [BYTE_W-1:0] data;
   } crc_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/sfc32_ifs.sv =====
// ----------------------------------------------------------------------------
// sfc32 channel interfaces
// Valid/ready channels for received bytes, frame words and the start word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc32_req_if;
   logic                            valid;
   logic                            ready;
   logic [sfc32_pkg::BYTE_W-1:0]    rx_byte;
   logic [sfc32_pkg::TIME_W-1:0]    timestamp;

   modport source (output valid, output rx_byte, output timestamp, input ready);
   modport sink   (input valid, input rx_byte, input timestamp, output ready);
endinterface

interface sfc32_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sfc32_pkg::BYTE_W-1:0]        frame_byte;
   logic [sfc32_pkg::BYTE_INDEX_W-1:0]  byte_index;
   logic                                last_of_frame;
   logic [sfc32_pkg::TIME_W-1:0]        frame_time;

   modport source (output valid, output frame_byte, output byte_index,
                   output last_of_frame, output frame_time, input ready);
   modport sink   (input valid, input frame_byte, input byte_index,
                   input last_of_frame, input frame_time, output ready);
endinterface

interface sfc32_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sfc32_pkg::START_WORD_W-1:0]  start_word;

   modport source (output valid, output start_word, input ready);
   modport sink   (input valid, input start_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfc32_ram.sv =====
// ----------------------------------------------------------------------------
// sfc32_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc32_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [$clog2(DEPTH)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]          wdata,
   input  wire logic                      re,
   input  wire logic [$clog2(DEPTH)-1:0]  raddr,
   output      logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/sfc32_crc_unit.sv =====
// ----------------------------------------------------------------------------
// sfc32_crc_unit
// Byte-wide reflected CRC-32 accumulator, one byte per cycle while step is set.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc32_crc_unit (
   input  wire logic                          clock,
   input  wire sfc32_pkg::crc_ctrl_type       ctrl,
   output      logic [sfc32_pkg::CRC_W-1:0]   crc
);

   logic [sfc32_pkg::CRC_W-1:0] crc_ff;
   logic [sfc32_pkg::CRC_W-1:0] crc_in;
   logic [sfc32_pkg::CRC_W-1:0] nxt;

   always_comb begin
      nxt = crc_ff ^ {{(sfc32_pkg::CRC_W-sfc32_pkg::BYTE_W){1'b0}}, ctrl.data};
      for (int b = 0; b < sfc32_pkg::BYTE_W; b++) begin
         if (nxt[0]) begin
            nxt = (nxt >> 1) ^ sfc32_pkg::CRC_POLY;
         end else begin
            nxt = nxt >> 1;
         end
      end
      priority if (ctrl.init) begin
         crc_in = sfc32_pkg::CRC_INIT;
      end else if (ctrl.step) begin
         crc_in = nxt;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_frame_crc32_check.sv =====
// ----------------------------------------------------------------------------
// sliding_window_frame_crc32_check
// Keeps the last FRAME_BYTES received bytes in a ring, looks for the start
// word at the oldest two bytes and emits the window when its CRC-32 matches.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                             accepted
//  req_chan  in   rx_byte, timestamp                                 valid & ready
//  rsp_chan  out  frame_byte, byte_index, last_of_frame, frame_time  valid & ready
//  csr_chan  in   start_word                                         valid & ready
//
//  A byte is checked in ST_CHK_RD0, ST_CHK_RD1 and ST_CHK_CMP; on a match the
//  CRC pass runs ST_CRC_RD and ST_CRC_ACC for each window byte, then
//  ST_CRC_CMP, and a valid frame emits each word through ST_EMIT_RD and
//  ST_EMIT_LD: one ring read port and a byte-wide CRC unit. Reset clears
//  the ring's valid bits at once; no clearing pass. rsp stalls hold the
//  sequencer; the final word may wait while a new byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_frame_crc32_check #(
   parameter int FRAME_BYTES = sfc32_pkg::FRAME_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sfc32_req_if.sink   req_chan,
   sfc32_rsp_if.source rsp_chan,
   sfc32_csr_if.sink   csr_chan
);

   localparam int PW = $clog2(FRAME_BYTES);
   localparam logic [PW:0]   N_W        = (PW+1)'(FRAME_BYTES);
   localparam logic [PW-1:0] LAST_IDX   = PW'(FRAME_BYTES - 1);
   localparam logic [PW-1:0] CRC_END    = PW'(FRAME_BYTES - sfc32_pkg::CRC_BYTES);
   localparam logic [PW-1:0] OFF_ONE    = PW'(1);
   localparam logic [PW-1:0] OFF_TWO    = PW'(2);

   function automatic logic [PW-1:0] ring_add(logic [PW-1:0] a, logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= N_W) begin
         s = s - N_W;
      end
      return s[PW-1:0];
   endfunction

   sfc32_pkg::state_type state_ff, state_in;

   logic [sfc32_pkg::START_WORD_W-1:0] start_word_ff;
   logic [PW-1:0]                      pos_ff, pos_in;
   logic [PW-1:0]                      idx_ff, idx_in;
   logic [FRAME_BYTES-1:0]             vld_ff, vld_in;
   logic                               rvld_ff;
   logic [sfc32_pkg::TIME_W-1:0]       ts_ff, ts_in;
   logic [sfc32_pkg::BYTE_W-1:0]       lo_ff, lo_in;
   logic [sfc32_pkg::CRC_W-1:0]        stored_ff, stored_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sfc32_pkg::BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic [sfc32_pkg::BYTE_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [sfc32_pkg::TIME_W-1:0]       rsp_time_ff, rsp_time_in;

   logic                               ram_we;
   logic [PW-1:0]                      ram_waddr;
   logic                               ram_re;
   logic [PW-1:0]                      ram_raddr;
   logic [sfc32_pkg::BYTE_W-1:0]       ram_rdata;
   logic [sfc32_pkg::BYTE_W-1:0]       rbyte;

   sfc32_pkg::crc_ctrl_type            crc_ctrl;
   logic [sfc32_pkg::CRC_W-1:0]        crc_val;

   logic [PW-1:0]                      oldest;
   logic                               req_acc;
   logic                               rsp_free;
   logic                               start_match;
   logic                               crc_match;

   sfc32_ram #(
      .WIDTH (sfc32_pkg::BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_chan.rx_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfc32_crc_unit u_crc (
      .clock (clock),
      .ctrl  (crc_ctrl),
      .crc   (crc_val)
   );

   assign req_chan.ready = (state_ff == sfc32_pkg::ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = (state_ff == sfc32_pkg::ST_IDLE);

   assign oldest      = ring_add(pos_ff, OFF_ONE);
   assign rbyte       = rvld_ff ? ram_rdata : '0;
   assign start_match = ({rbyte, lo_ff} == start_word_ff);
   assign crc_match   = ((crc_val ^ sfc32_pkg::CRC_XOROUT) == stored_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      vld_in       = vld_ff;
      ts_in        = ts_ff;
      lo_in        = lo_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_time_in  = rsp_time_ff;
      ram_we       = 1'b0;
      ram_waddr    = ring_add(pos_ff, OFF_ONE);
      ram_re       = 1'b0;
      ram_raddr    = ring_add(oldest, idx_ff);
      crc_ctrl     = '{init: 1'b0, step: 1'b0, data: rbyte};

      unique case (state_ff)
         sfc32_pkg::ST_IDLE: begin
            if (req_acc) begin
               ram_we            = 1'b1;
               pos_in            = ram_waddr;
               vld_in[ram_waddr] = 1'b1;
               ts_in             = req_chan.timestamp;
               state_in          = sfc32_pkg::ST_CHK_RD0;
            end
         end
         sfc32_pkg::ST_CHK_RD0: begin
            ram_re    = 1'b1;
            ram_raddr = oldest;
            state_in  = sfc32_pkg::ST_CHK_RD1;
         end
         sfc32_pkg::ST_CHK_RD1: begin
            lo_in     = rbyte;
            ram_re    = 1'b1;
            ram_raddr = ring_add(pos_ff, OFF_TWO);
            state_in  = sfc32_pkg::ST_CHK_CMP;
         end
         sfc32_pkg::ST_CHK_CMP: begin
            idx_in        = '0;
            crc_ctrl.init = 1'b1;
            state_in      = start_match ? sfc32_pkg::ST_CRC_RD : sfc32_pkg::ST_IDLE;
         end
         sfc32_pkg::ST_CRC_RD: begin
            ram_re   = 1'b1;
            state_in = sfc32_pkg::ST_CRC_ACC;
         end
         sfc32_pkg::ST_CRC_ACC: begin
            if (idx_ff < CRC_END) begin
               crc_ctrl.step = 1'b1;
            end else begin
               stored_in = {rbyte, stored_ff[sfc32_pkg::CRC_W-1:sfc32_pkg::BYTE_W]};
            end
            if (idx_ff == LAST_IDX) begin
               state_in = sfc32_pkg::ST_CRC_CMP;
            end else begin
               idx_in   = idx_ff + OFF_ONE;
               state_in = sfc32_pkg::ST_CRC_RD;
            end
         end
         sfc32_pkg::ST_CRC_CMP: begin
            idx_in   = '0;
            state_in = crc_match ? sfc32_pkg::ST_EMIT_RD : sfc32_pkg::ST_IDLE;
         end
         sfc32_pkg::ST_EMIT_RD: begin
            ram_re   = 1'b1;
            state_in = sfc32_pkg::ST_EMIT_LD;
         end
         sfc32_pkg::ST_EMIT_LD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rbyte;
               rsp_index_in = sfc32_pkg::BYTE_INDEX_W'(idx_ff);
               rsp_last_in  = (idx_ff == LAST_IDX);
               rsp_time_in  = ts_ff;
               if (idx_ff == LAST_IDX) begin
                  state_in = sfc32_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + OFF_ONE;
                  state_in = sfc32_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = sfc32_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfc32_pkg::ST_IDLE;
         start_word_ff <= sfc32_pkg::START_WORD_RESET;
         pos_ff        <= '0;
         vld_ff        <= '0;
         rvld_ff       <= 1'b0;
         ts_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vld_ff       <= vld_in;
         ts_ff        <= ts_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            start_word_ff <= csr_chan.start_word;
         end
         if (ram_re) begin
            rvld_ff <= vld_ff[ram_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      stored_ff    <= stored_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.frame_byte    = rsp_byte_ff;
   assign rsp_chan.byte_index    = rsp_index_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;
   assign rsp_chan.frame_time    = rsp_time_ff;

   // emission starts only after a passing CRC compare
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfc32_pkg::ST_EMIT_RD && $past(state_ff) == sfc32_pkg::ST_CRC_CMP)
         |-> $past(crc_match))
      else $error("frame emitted without CRC match");

   // only the final word of a frame may still be pending when a new byte arrives
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && rsp_valid_ff) |-> rsp_last_ff)
      else $error("new byte taken mid-frame");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == sfc32_pkg::BYTE_INDEX_W'(LAST_IDX)))
      else $error("last marker on wrong index");

endmodule

`default_nettype wire

// ===== sim/sliding_window_frame_crc32_check_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_frame_crc32_check_tb
// Drives received bytes with timestamps into the frame synchronizer and
// checks every emitted frame word against a model of the byte window, the
// start-word match and the reflected CRC-32 over the frame body. Covers the
// not-yet-filled window, corrupted, truncated and noisy byte streams, several
// start words, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------

module sliding_window_frame_crc32_check_tb;

   localparam int FRAME_LEN   = sfc32_pkg::FRAME_BYTES_DEF;
   localparam int CRC_LEN     = sfc32_pkg::CRC_BYTES;
   localparam int BODY_LEN    = FRAME_LEN - CRC_LEN;
   localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;

   localparam int PHASES          = 6;
   localparam int BYTES_PER_PHASE = 44;
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_CYCLES     = 600;
   localparam int MAX_CYCLES      = 2_000_000;
   localparam int MAX_REPORTS     = 20;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [5:0]  byte_index;
      logic        last_of_frame;
      logic [31:0] frame_time;
   } frame_word_type;

   class frame_scoreboard;
      frame_word_type pending_words[$];
      logic [7:0]     window[FRAME_LEN];
      int             newest;
      logic [15:0]    start_word;
      int             mismatches;
      int             words_checked;
      int             frames_matched;

      function new();
         foreach (window[i]) window[i] = 8'h00;
         newest         = 0;
         start_word     = sfc32_pkg::START_WORD_RESET;
         mismatches     = 0;
         words_checked  = 0;
         frames_matched = 0;
      endfunction

      static function logic [31:0] crc32_of(frame_type f, int n);
         logic [31:0] c;
         c = CRC_ONES;
         for (int i = 0; i < n; i++) begin
            c ^= {24'h0, f[i]};
            for (int b = 0; b < 8; b++)
               c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
         end
         return c ^ CRC_ONES;
      endfunction

      function void note_byte(logic [7:0] rx, logic [31:0] ts);
         frame_type      f;
         frame_word_type w;
         int             oldest;
         newest         = (newest + 1) % FRAME_LEN;
         window[newest] = rx;
         oldest         = (newest + 1) % FRAME_LEN;
         for (int i = 0; i < FRAME_LEN; i++)
            f[i] = window[(oldest + i) % FRAME_LEN];
         if ({f[1], f[0]} != start_word)
            return;
         if (crc32_of(f, BODY_LEN) !=
             {f[FRAME_LEN-1], f[FRAME_LEN-2], f[FRAME_LEN-3], f[FRAME_LEN-4]})
            return;
         frames_matched++;
         for (int i = 0; i < FRAME_LEN; i++) begin
            w.frame_byte    = f[i];
            w.byte_index    = 6'(i);
            w.last_of_frame = (i == FRAME_LEN - 1);
            w.frame_time    = ts;
            pending_words.push_back(w);
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
      endtask

      task check_word(frame_word_type got);
         frame_word_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word: byte %h index %0d last %b time %h",
                             got.frame_byte, got.byte_index, got.last_of_frame,
                             got.frame_time));
            return;
         end
         want = pending_words.pop_front();
         if (got.frame_byte != want.frame_byte)
            report($sformatf("frame_byte %h, want %h (index %0d)",
                             got.frame_byte, want.frame_byte, want.byte_index));
         if (got.byte_index != want.byte_index)
            report($sformatf("byte_index %0d, want %0d",
                             got.byte_index, want.byte_index));
         if (got.last_of_frame != want.last_of_frame)
            report($sformatf("last_of_frame %b, want %b (index %0d)",
                             got.last_of_frame, want.last_of_frame, want.byte_index));
         if (got.frame_time != want.frame_time)
            report($sformatf("frame_time %h, want %h (index %0d)",
                             got.frame_time, want.frame_time, want.byte_index));
      endtask
   endclass

   logic clock;
   logic reset;

   sfc32_req_if req_bus ();
   sfc32_rsp_if rsp_bus ();
   sfc32_csr_if csr_bus ();

   sliding_window_frame_crc32_check #(
      .FRAME_BYTES (FRAME_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   frame_scoreboard sb = new();

   int   bytes_sent  = 0;
   int   words_tried = 0;
   int   cycles      = 0;
   int   stall_left  = 0;
   logic idle_on     = 1'b1;
   logic pressure_go = 1'b0;
   logic rsp_hold    = 1'b0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int idle_len();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic frame_type make_frame(logic [15:0] sw);
      frame_type   f;
      logic [31:0] crc;
      f[0] = sw[7:0];
      f[1] = sw[15:8];
      for (int i = 2; i < BODY_LEN; i++)
         f[i] = 8'($urandom_range(0, 255));
      crc = frame_scoreboard::crc32_of(f, BODY_LEN);
      for (int k = 0; k < CRC_LEN; k++)
         f[BODY_LEN + k] = crc[8*k +: 8];
      return f;
   endfunction

   // valid stays high after acceptance; the next call lowers it or reloads it
   task automatic send_byte(logic [7:0] b, logic [31:0] ts);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.rx_byte   = b;
      req_bus.timestamp = ts;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(b, ts);
      bytes_sent++;
   endtask

   task automatic send_frame(frame_type f, int count);
      for (int i = 0; i < count; i++)
         send_byte(f[i], $urandom());
   endtask

   task automatic send_random_chunk();
      int        kind;
      int        flip;
      frame_type f;
      kind = $urandom_range(0, 99);
      f    = make_frame(sb.start_word);
      if (kind < 65) begin
         send_frame(f, FRAME_LEN);
      end else if (kind < 80) begin
         // single bit error past the start word
         flip = $urandom_range(16, FRAME_LEN*8 - 1);
         f    = f ^ (frame_type'(1) << flip);
         send_frame(f, FRAME_LEN);
      end else if (kind < 88) begin
         send_frame(f, $urandom_range(2, FRAME_LEN - 1));
      end else begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), $urandom());
      end
   endtask

   task automatic write_start_word(logic [15:0] w);
      @(negedge clock);
      csr_bus.valid      = 1'b1;
      csr_bus.start_word = w;
      do @(posedge clock); while (!csr_bus.ready);
      sb.start_word = w;
      words_tried++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall_left    = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_word({rsp_bus.frame_byte, rsp_bus.byte_index,
                        rsp_bus.last_of_frame, rsp_bus.frame_time});
   end

   // long output stall while input keeps coming
   initial begin
      wait (pressure_go);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      while (cycles < MAX_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      frame_type   f;
      logic [15:0] word;
      int          phase_start;

      req_bus.valid      = 1'b0;
      req_bus.rx_byte    = 8'h00;
      req_bus.timestamp  = 32'h0;
      csr_bus.valid      = 1'b0;
      csr_bus.start_word = 16'h0000;
      reset              = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero start word: unwritten slots form the start word, early bytes
      // hit the start word with a bad CRC, the frame's last byte completes a valid frame
      write_start_word(16'h0000);
      f = make_frame(16'h0000);
      for (int i = 2; i < FRAME_LEN - 1; i++)
         send_byte(f[i], $urandom());
      send_byte(f[FRAME_LEN-1], 32'hFFFF_FFFF);
      send_byte(8'h00, 32'h0000_0000);
      send_byte(8'hFF, 32'hFFFF_FFFF);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1:       word = 16'hFFFF;
               2:       word = sfc32_pkg::START_WORD_RESET;
               4:       word = 16'h0001;
               default: word = 16'($urandom_range(0, 16'hFFFF));
            endcase
            write_start_word(word);
         end
         idle_on = (p != 2);
         phase_start = bytes_sent;
         if (p == 3) begin
            @(posedge clock);
            pressure_go = 1'b1;
            send_frame(make_frame(sb.start_word), FRAME_LEN);
            send_frame(make_frame(sb.start_word), FRAME_LEN);
         end
         while (bytes_sent - phase_start < BYTES_PER_PHASE)
            send_random_chunk();
      end
      settle();

      $display("summary: %0d bytes in, %0d frames matched, %0d words checked",
               bytes_sent, sb.frames_matched, sb.words_checked);
      $display("summary: %0d start words, output held %0d cycles once, %0d mismatches",
               words_tried, HOLD_CYCLES, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
